/* rtl/jsu_pkg.sv */
// ============================================================================
// jsu_pkg
// Types, constants and helper functions for the JSON string unescape block.
// ============================================================================
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        ST_ONGOING = 3'd0,
        ST_DONE    = 3'd1,
        ST_NOQUOTE = 3'd2,
        ST_BADESC  = 3'd3,
        ST_BADHEX  = 3'd4,
        ST_BADSURR = 3'd5,
        ST_BADCTRL = 3'd6
    } t_status;

    typedef enum logic [6:0] {
        M_IDLE     = 7'b0000001,
        M_NORMAL   = 7'b0000010,
        M_ESC      = 7'b0000100,
        M_HEX1     = 7'b0001000,
        M_WANT_BSL = 7'b0010000,
        M_WANT_U   = 7'b0100000,
        M_HEX2     = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       begin_req;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        t_status    status;
        logic       last;
    } t_out;

    // one decoded input byte: up to four output bytes, byte 0 in the low lane
    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  last_idx;
        logic        byte_valid;
        t_status     status;
    } t_job;

    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_BSL     = 8'h5C;
    localparam logic [7:0]  CH_U       = 8'h75;
    localparam logic [7:0]  CH_NUL     = 8'h00;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;

    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [20:0] MAX_1BYTE  = 21'h7F;
    localparam logic [20:0] MAX_2BYTE  = 21'h7FF;
    localparam logic [20:0] MAX_3BYTE  = 21'hFFFF;
    localparam logic [7:0]  LEAD_2     = 8'hC0;
    localparam logic [7:0]  LEAD_3     = 8'hE0;
    localparam logic [7:0]  LEAD_4     = 8'hF0;
    localparam logic [7:0]  CONT       = 8'h80;

    // bit 4 set when the byte is a hex digit, value in bits 3:0
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    // bit 8 set when the byte is not a single-character escape
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h22:   r = 9'h022;
            8'h5C:   r = 9'h05C;
            8'h2F:   r = 9'h02F;
            8'h62:   r = 9'h008;
            8'h66:   r = 9'h00C;
            8'h6E:   r = 9'h00A;
            8'h72:   r = 9'h00D;
            8'h74:   r = 9'h009;
            default: r = 9'h100;
        endcase
        return r;
    endfunction

    function automatic t_job utf8_encode(input logic [20:0] cp);
        t_job j;
        j.data       = '0;
        j.byte_valid = 1'b1;
        j.status     = ST_ONGOING;
        if (cp <= MAX_1BYTE) begin
            j.data[7:0] = cp[7:0];
            j.last_idx  = 2'd0;
        end else if (cp <= MAX_2BYTE) begin
            j.data[7:0]   = LEAD_2 | {3'b000, cp[10:6]};
            j.data[15:8]  = CONT | {2'b00, cp[5:0]};
            j.last_idx    = 2'd1;
        end else if (cp <= MAX_3BYTE) begin
            j.data[7:0]   = LEAD_3 | {4'b0000, cp[15:12]};
            j.data[15:8]  = CONT | {2'b00, cp[11:6]};
            j.data[23:16] = CONT | {2'b00, cp[5:0]};
            j.last_idx    = 2'd2;
        end else begin
            j.data[7:0]   = LEAD_4 | {5'b00000, cp[20:18]};
            j.data[15:8]  = CONT | {2'b00, cp[17:12]};
            j.data[23:16] = CONT | {2'b00, cp[11:6]};
            j.data[31:24] = CONT | {2'b00, cp[5:0]};
            j.last_idx    = 2'd3;
        end
        return j;
    endfunction

endpackage

`default_nettype wire

/* rtl/jsu_front.sv */
// ============================================================================
// jsu_front
// Escape decoder: takes one string byte per transaction and builds a job
// holding all the output bytes, or the terminal status, that it produces.
// ============================================================================
`default_nettype none

module jsu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_fire,
    input  wire jsu_pkg::t_in i_data,
    output logic              o_push,
    output jsu_pkg::t_job     o_job
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode, eff_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_code_unit, n_code_unit, cu_shift;
    logic [9:0]  r_high_bits, n_high_bits;
    logic [4:0]  hv;
    logic [8:0]  se;
    logic [7:0]  b;
    logic        term;
    t_status     term_st;
    t_job        job;

    always_comb begin
        b           = i_data.in_byte;
        hv          = hex_value(b);
        se          = simple_escape(b);
        cu_shift    = {r_code_unit[11:0], hv[3:0]};
        eff_mode    = i_data.begin_req ? M_NORMAL : r_mode;
        n_mode      = eff_mode;
        n_hex_cnt   = r_hex_cnt;
        n_code_unit = r_code_unit;
        n_high_bits = r_high_bits;
        term        = 1'b0;
        term_st     = ST_ONGOING;
        job         = '{data: '0, last_idx: 2'd0, byte_valid: 1'b0, status: ST_ONGOING};

        unique case (eff_mode) inside
            M_NORMAL: begin
                if (b == CH_QUOTE) begin
                    term    = 1'b1;
                    term_st = ST_DONE;
                end else if (b == CH_NUL) begin
                    term    = 1'b1;
                    term_st = ST_NOQUOTE;
                end else if (b == CH_BSL) begin
                    n_mode = M_ESC;
                end else if (b < CTRL_LIMIT) begin
                    term    = 1'b1;
                    term_st = ST_BADCTRL;
                end else begin
                    job.data[7:0]  = b;
                    job.byte_valid = 1'b1;
                end
            end
            M_ESC: begin
                if (b == CH_U) begin
                    n_mode      = M_HEX1;
                    n_hex_cnt   = 2'd0;
                    n_code_unit = '0;
                end else if (!se[8]) begin
                    job.data[7:0]  = se[7:0];
                    job.byte_valid = 1'b1;
                    n_mode         = M_NORMAL;
                end else begin
                    term    = 1'b1;
                    term_st = ST_BADESC;
                end
            end
            M_HEX1, M_HEX2: begin
                if (!hv[4]) begin
                    term    = 1'b1;
                    term_st = ST_BADHEX;
                end else begin
                    n_code_unit = cu_shift;
                    if (r_hex_cnt != 2'd3) begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end else begin
                        n_hex_cnt = 2'd0;
                        if (eff_mode == M_HEX1) begin
                            if (cu_shift >= HI_SURR_LO && cu_shift <= HI_SURR_HI) begin
                                n_high_bits = cu_shift[9:0];
                                n_mode      = M_WANT_BSL;
                            end else begin
                                job    = utf8_encode({5'b00000, cu_shift});
                                n_mode = M_NORMAL;
                            end
                        end else if (cu_shift >= LO_SURR_LO && cu_shift <= LO_SURR_HI) begin
                            job    = utf8_encode({1'b0, r_high_bits, cu_shift[9:0]} + SUPP_BASE);
                            n_mode = M_NORMAL;
                        end else begin
                            term    = 1'b1;
                            term_st = ST_BADSURR;
                        end
                    end
                end
            end
            M_WANT_BSL: begin
                if (b == CH_BSL) begin
                    n_mode = M_WANT_U;
                end else begin
                    term    = 1'b1;
                    term_st = ST_BADSURR;
                end
            end
            M_WANT_U: begin
                if (b == CH_U) begin
                    n_mode      = M_HEX2;
                    n_hex_cnt   = 2'd0;
                    n_code_unit = '0;
                end else begin
                    term    = 1'b1;
                    term_st = ST_BADSURR;
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        if (term) begin
            job        = '{data: '0, last_idx: 2'd0, byte_valid: 1'b0, status: term_st};
            n_mode     = M_IDLE;
        end
    end

    // idle bytes without a begin flag are dropped silently
    assign o_push = i_fire && (eff_mode != M_IDLE);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_hex_cnt   <= 2'd0;
            r_code_unit <= '0;
            r_high_bits <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_hex_cnt   <= n_hex_cnt;
            r_code_unit <= n_code_unit;
            r_high_bits <= n_high_bits;
        end
    end

endmodule

`default_nettype wire

/* rtl/jsu_queue.sv */
// ============================================================================
// jsu_queue
// Small job queue between the decoder and the byte serializer.
// ============================================================================
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jsu_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_nempty,
    output jsu_pkg::t_job      o_job
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_job    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/jsu_back.sv */
// ============================================================================
// jsu_back
// Serializer: holds one job and hands out its bytes one transaction at a time.
// ============================================================================
`default_nettype none

module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_avail,
    input  wire jsu_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output jsu_pkg::t_out      o_data
);
    import jsu_pkg::*;

    t_job        r_job;
    logic [1:0]  r_idx;
    logic        r_busy;
    logic        is_last;
    logic [31:0] lane;

    assign is_last = (r_idx == r_job.last_idx);
    assign lane    = r_job.data >> {r_idx, 3'b000};
    assign o_pop   = i_job_avail && (!r_busy || (i_ready && is_last));
    assign o_valid = r_busy;

    always_comb begin
        o_data.out_byte   = lane[7:0];
        o_data.byte_valid = r_job.byte_valid;
        o_data.status     = r_job.status;
        o_data.last       = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (r_busy && i_ready) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/json_string_unescape_utf8.sv */
// Path: an accepted byte is decoded and its job written into the queue; the
// serializer then loads that job into its register, which raises o_out_valid.
// Throughput: one input byte per cycle while the job queue is not full; the
// serializer gives one result per cycle while i_out_ready is high, so the n
// UTF-8 bytes of a \u escape hold it while the queue absorbs further input.
// Reset: synchronous active low; decoder returns to idle, queue and output empty.
// ============================================================================
// json_string_unescape_utf8
// JSON string body decoder producing UTF-8 bytes and a terminal status.
// ============================================================================
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire jsu_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output jsu_pkg::t_out      o_out_data
);
    import jsu_pkg::*;

    logic q_full, q_nempty, q_pop, push;
    t_job front_job, head_job;

    assign o_in_ready = !q_full;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (i_in_valid && o_in_ready),
        .i_data  (i_in_data),
        .o_push  (push),
        .o_job   (front_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_job    (head_job)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (q_nempty),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule

`default_nettype wire

/* test/json_string_unescape_utf8_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// json_string_unescape_utf8_checker
// Watches both channels of the JSON string unescape block. Every accepted
// input byte is decoded here into the UTF-8 bytes and status it must cause.
// Every accepted result is then compared with the oldest of those, field by
// field.
// ============================================================================

module json_string_unescape_utf8_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  jsu_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  jsu_pkg::t_out i_out_data,
    output int            o_pending,
    output int            o_errors,
    output int            o_checked,
    output logic [6:0]    o_status_seen
);
    import jsu_pkg::*;

    t_mode       mode      = M_IDLE;
    logic [1:0]  digit_cnt = '0;
    logic [15:0] unit      = '0;
    logic [9:0]  hi_bits   = '0;
    t_out        decoded_q[$];
    t_out        got;
    t_out        want;

    initial begin
        o_pending     = 0;
        o_errors      = 0;
        o_checked     = 0;
        o_status_seen = '0;
    end

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= "0" && b <= "9") begin
            v = b - "0";
            return {1'b1, v[3:0]};
        end
        if (b >= "A" && b <= "F") begin
            v = b - "A" + 8'd10;
            return {1'b1, v[3:0]};
        end
        if (b >= "a" && b <= "f") begin
            v = b - "a" + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    // bit 8 flags a byte that is no single-character escape
    function automatic logic [8:0] escape_byte(input logic [7:0] b);
        case (b)
            CH_QUOTE: return {1'b0, CH_QUOTE};
            CH_BSL:   return {1'b0, CH_BSL};
            "/":      return {1'b0, 8'h2F};
            "b":      return 9'h008;
            "f":      return 9'h00C;
            "n":      return 9'h00A;
            "r":      return 9'h00D;
            "t":      return 9'h009;
            default:  return 9'h100;
        endcase
    endfunction

    // code point to UTF-8, first byte in the low lane; returns the byte count
    function automatic int to_utf8(input logic [20:0] cp, output logic [31:0] seq);
        seq = '0;
        if (cp <= MAX_1BYTE) begin
            seq[7:0] = cp[7:0];
            return 1;
        end
        if (cp <= MAX_2BYTE) begin
            seq[7:0]  = LEAD_2 | {3'b000, cp[10:6]};
            seq[15:8] = CONT | {2'b00, cp[5:0]};
            return 2;
        end
        if (cp <= MAX_3BYTE) begin
            seq[7:0]   = LEAD_3 | {4'b0000, cp[15:12]};
            seq[15:8]  = CONT | {2'b00, cp[11:6]};
            seq[23:16] = CONT | {2'b00, cp[5:0]};
            return 3;
        end
        seq[7:0]   = LEAD_4 | {5'b00000, cp[20:18]};
        seq[15:8]  = CONT | {2'b00, cp[17:12]};
        seq[23:16] = CONT | {2'b00, cp[11:6]};
        seq[31:24] = CONT | {2'b00, cp[5:0]};
        return 4;
    endfunction

    task automatic decode_step(input t_in item);
        logic [7:0]  b;
        logic [4:0]  nib;
        logic [8:0]  esc;
        logic [15:0] offset;
        logic [20:0] cp;
        logic [31:0] seq;
        logic        have_cp;
        logic        ended;
        t_status     term;
        t_out        res[4];
        int          cnt;
        int          n;
        int          i;

        b       = item.in_byte;
        have_cp = 1'b0;
        ended   = 1'b0;
        term    = ST_ONGOING;
        cnt     = 0;
        cp      = '0;

        if (item.begin_req) begin
            mode      = M_NORMAL;
            digit_cnt = '0;
            unit      = '0;
            hi_bits   = '0;
        end

        case (mode)
            M_NORMAL: begin
                if (b == CH_QUOTE) begin
                    term  = ST_DONE;
                    ended = 1'b1;
                end else if (b == CH_NUL) begin
                    term  = ST_NOQUOTE;
                    ended = 1'b1;
                end else if (b == CH_BSL) begin
                    mode = M_ESC;
                end else if (b < CTRL_LIMIT) begin
                    term  = ST_BADCTRL;
                    ended = 1'b1;
                end else begin
                    res[2'(cnt)] = '{out_byte: b, byte_valid: 1'b1, status: ST_ONGOING,
                                     last: 1'b0};
                    cnt++;
                end
            end
            M_ESC: begin
                esc = escape_byte(b);
                if (b == CH_U) begin
                    mode      = M_HEX1;
                    digit_cnt = '0;
                    unit      = '0;
                end else if (!esc[8]) begin
                    res[2'(cnt)] = '{out_byte: esc[7:0], byte_valid: 1'b1,
                                     status: ST_ONGOING, last: 1'b0};
                    cnt++;
                    mode = M_NORMAL;
                end else begin
                    term  = ST_BADESC;
                    ended = 1'b1;
                end
            end
            M_HEX1, M_HEX2: begin
                nib = hex_digit(b);
                if (!nib[4]) begin
                    term  = ST_BADHEX;
                    ended = 1'b1;
                end else begin
                    unit = {unit[11:0], nib[3:0]};
                    if (digit_cnt != 2'd3) begin
                        digit_cnt = digit_cnt + 2'd1;
                    end else begin
                        digit_cnt = '0;
                        if (mode == M_HEX1 && unit >= HI_SURR_LO && unit <= HI_SURR_HI) begin
                            offset  = unit - HI_SURR_LO;
                            hi_bits = offset[9:0];
                            mode    = M_WANT_BSL;
                        end else if (mode == M_HEX1) begin
                            // lone low surrogates land here too and encode as three bytes
                            cp      = {5'd0, unit};
                            have_cp = 1'b1;
                            mode    = M_NORMAL;
                        end else if (unit >= LO_SURR_LO && unit <= LO_SURR_HI) begin
                            offset  = unit - LO_SURR_LO;
                            cp      = {1'b0, hi_bits, offset[9:0]} + SUPP_BASE;
                            have_cp = 1'b1;
                            mode    = M_NORMAL;
                        end else begin
                            term  = ST_BADSURR;
                            ended = 1'b1;
                        end
                    end
                end
            end
            M_WANT_BSL: begin
                if (b == CH_BSL) begin
                    mode = M_WANT_U;
                end else begin
                    term  = ST_BADSURR;
                    ended = 1'b1;
                end
            end
            M_WANT_U: begin
                if (b == CH_U) begin
                    mode      = M_HEX2;
                    digit_cnt = '0;
                    unit      = '0;
                end else begin
                    term  = ST_BADSURR;
                    ended = 1'b1;
                end
            end
            default: begin
                // idle without a begin flag: byte dropped, nothing comes out
                mode = M_IDLE;
                return;
            end
        endcase

        if (have_cp) begin
            n = to_utf8(cp, seq);
            for (i = 0; i < n; i++) begin
                res[2'(cnt)] = '{out_byte: seq[8*i +: 8], byte_valid: 1'b1,
                                 status: ST_ONGOING, last: 1'b0};
                cnt++;
            end
        end

        if (ended) begin
            res[2'(cnt)] = '{out_byte: 8'h00, byte_valid: 1'b0, status: term, last: 1'b0};
            cnt++;
            mode = M_IDLE;
        end else if (cnt == 0) begin
            res[2'(cnt)] = '{out_byte: 8'h00, byte_valid: 1'b0, status: ST_ONGOING,
                             last: 1'b0};
            cnt++;
        end

        res[2'(cnt - 1)].last = 1'b1;
        for (i = 0; i < cnt; i++) begin
            decoded_q.push_back(res[2'(i)]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode      = M_IDLE;
            digit_cnt = '0;
            unit      = '0;
            hi_bits   = '0;
            decoded_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (decoded_q.size() == 0) begin
                    $error("result with none pending: out_byte %02h byte_valid %0d status %0d",
                           got.out_byte, got.byte_valid, got.status);
                    o_errors++;
                end else begin
                    want = decoded_q.pop_front();
                    o_checked++;
                    if (got.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                        o_errors++;
                    end
                    if (got.byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0d, got %0d", want.byte_valid,
                               got.byte_valid);
                        o_errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        o_errors++;
                    end
                    o_status_seen[want.status] = 1'b1;
                end
            end
            // input transaction: predict what it must produce
            if (i_in_valid && i_in_ready) begin
                decode_step(i_in_data);
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

/* test/json_string_unescape_utf8_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// json_string_unescape_utf8_tb
// Feeds JSON string bodies byte by byte into the unescape block: a few fixed
// strings first, then random ones built from plain bytes, simple escapes,
// \u units and surrogate pairs, ended by a quote or an error, or left open.
// Both channels idle at random; the checker beside the block does the scoring.
// ============================================================================

module json_string_unescape_utf8_tb;

    import jsu_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT        = 500000;
    localparam int RANDOM_BYTES = 430;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [15:0] EDGE_UNITS [10] = '{
        16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
        16'hD7FF, 16'hDC00, 16'hDFFF, 16'hE000, 16'hFFFF
    };

    typedef enum {
        END_QUOTE,
        END_NUL,
        END_CTRL,
        END_BAD_ESC,
        END_BAD_HEX,
        END_NO_BSL,
        END_NO_U,
        END_BAD_HEX2,
        END_NOT_LOW,
        END_NONE
    } t_body_end;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in        in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out       out_data;

    int         pending;
    int         errors;
    int         checked;
    logic [6:0] status_seen;

    bit         hold_req  = 1'b0;
    bit         holding   = 1'b0;
    int         cycles    = 0;
    int         bytes_sent = 0;
    int         bodies    = 0;
    int         ignored   = 0;
    logic [7:0] body_q[$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    json_string_unescape_utf8 i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    json_string_unescape_utf8_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_pending     (pending),
        .o_errors      (errors),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] alpha;
        alpha = $urandom_range(0, 1) ? "A" : "a";
        if (v < 4'd10) return "0" + v;
        return alpha + v - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h00, 8'h2F));
            1:       return 8'($urandom_range(8'h3A, 8'h40));
            2:       return 8'($urandom_range(8'h47, 8'h60));
            default: return 8'($urandom_range(8'h67, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 7))
            0:       return CH_QUOTE;
            1:       return CH_BSL;
            2:       return "/";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    // any byte other than the one given, with a zero byte now and then
    function automatic logic [7:0] other_than(input logic [7:0] ch);
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) return CH_NUL;
        do b = 8'($urandom_range(0, 255)); while (b == ch);
        return b;
    endfunction

    function automatic logic [15:0] pick_unit();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
            4:       return 16'($urandom_range(LO_SURR_LO, LO_SURR_HI));
            default: return EDGE_UNITS[4'($urandom_range(0, 9))];
        endcase
    endfunction

    function automatic logic [15:0] pick_high();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? HI_SURR_HI : HI_SURR_LO;
        return 16'($urandom_range(HI_SURR_LO, HI_SURR_HI));
    endfunction

    function automatic logic [15:0] pick_low();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? LO_SURR_HI : LO_SURR_LO;
        return 16'($urandom_range(LO_SURR_LO, LO_SURR_HI));
    endfunction

    task automatic push_unit(input logic [15:0] u);
        int k;
        body_q.push_back(CH_BSL);
        body_q.push_back(CH_U);
        for (k = 3; k >= 0; k--) begin
            body_q.push_back(hex_char(u[4*k +: 4]));
        end
    endtask

    task automatic push_digits();
        repeat ($urandom_range(0, 3)) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic build_body(output bit ends_idle);
        int         tokens;
        int         r;
        logic [7:0] b;
        logic [15:0] u;
        t_body_end  ending;

        body_q.delete();
        tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        repeat (tokens) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSL);
                body_q.push_back(b);
            end else if (r < 55) begin
                body_q.push_back(CH_BSL);
                body_q.push_back(escape_letter());
            end else if (r < 82) begin
                push_unit(pick_unit());
            end else begin
                push_unit(pick_high());
                push_unit(pick_low());
            end
        end

        ends_idle = 1'b1;
        ending = ($urandom_range(0, 99) < 70) ? END_QUOTE
                 : t_body_end'($urandom_range(END_NUL, END_NONE));
        case (ending)
            END_QUOTE: body_q.push_back(CH_QUOTE);
            END_NUL:   body_q.push_back(CH_NUL);
            END_CTRL:  body_q.push_back(8'($urandom_range(1, CTRL_LIMIT - 1)));
            END_BAD_ESC: begin
                body_q.push_back(CH_BSL);
                if ($urandom_range(0, 3) == 0) begin
                    b = CH_NUL;
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {CH_QUOTE, CH_BSL, CH_U, "/", "b", "f", "n", "r", "t"});
                end
                body_q.push_back(b);
            end
            END_BAD_HEX: begin
                body_q.push_back(CH_BSL);
                body_q.push_back(CH_U);
                push_digits();
                body_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : non_hex());
            end
            END_NO_BSL: begin
                push_unit(pick_high());
                body_q.push_back(other_than(CH_BSL));
            end
            END_NO_U: begin
                push_unit(pick_high());
                body_q.push_back(CH_BSL);
                body_q.push_back(other_than(CH_U));
            end
            END_BAD_HEX2: begin
                push_unit(pick_high());
                body_q.push_back(CH_BSL);
                body_q.push_back(CH_U);
                push_digits();
                body_q.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : non_hex());
            end
            END_NOT_LOW: begin
                push_unit(pick_high());
                if ($urandom_range(0, 3) == 0) begin
                    u = $urandom_range(0, 1) ? HI_SURR_HI : 16'hE000;
                end else begin
                    do u = 16'($urandom_range(0, 16'hFFFF));
                    while (u >= LO_SURR_LO && u <= LO_SURR_HI);
                end
                push_unit(u);
            end
            default: begin
                // left open, part way into an escape; the next begin flag restarts it
                ends_idle = 1'b0;
                case ($urandom_range(0, 3))
                    0: body_q.push_back(CH_BSL);
                    1: begin
                        body_q.push_back(CH_BSL);
                        body_q.push_back(CH_U);
                        push_digits();
                    end
                    2: push_unit(pick_high());
                    default: begin
                        push_unit(pick_high());
                        body_q.push_back(CH_BSL);
                    end
                endcase
            end
        endcase
    endtask

    // many multi-byte units in a row, sent back to back while the output is held
    task automatic build_fill();
        body_q.delete();
        repeat (8) begin
            if ($urandom_range(0, 1)) begin
                push_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
            end else begin
                push_unit(pick_high());
                push_unit(pick_low());
            end
        end
        body_q.push_back(CH_QUOTE);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first);
        in_data  <= '{in_byte: b, begin_req: first};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic send_body(input bit with_gaps);
        int k;
        for (k = 0; k < body_q.size(); k++) begin
            send_byte(body_q[k], k == 0);
            bytes_sent++;
            if (with_gaps) idle_gap(pick_gap());
        end
        bodies++;
    endtask

    // result side: random stalls, long ready stretches, and a hold on request
    initial begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding  = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end else begin
                out_ready <= 1'b1;
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 6);
                repeat (n) @(posedge clk);
                n = $urandom_range(0, 99);
                n = (n < 70) ? $urandom_range(1, 2)
                    : (n < 95) ? $urandom_range(3, 8) : $urandom_range(15, 40);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial begin
        int start;
        bit ends_idle;
        bit held;
        bit drained;

        held    = 1'b0;
        drained = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // highest code point from a surrogate pair, then a byte seen while idle
        body_q = '{CH_BSL, CH_U, "D", "B", "F", "F", CH_BSL, CH_U, "d", "f", "f", "f", CH_QUOTE};
        send_body(1'b1);
        send_byte(8'hFF, 1'b0);
        ignored++;
        idle_gap(2);
        body_q = '{CH_BSL, "q"};
        send_body(1'b1);
        body_q = '{8'hFF, 8'h20, CH_NUL};
        send_body(1'b1);
        body_q = '{8'h1F};
        send_body(1'b1);
        body_q = '{CH_QUOTE};
        send_body(1'b1);
        wait_drained();

        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (!held && bytes_sent - start >= 150) begin
                held = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                hold_req = 1'b1;
                wait (holding);
                build_fill();
                send_body(1'b0);
            end else begin
                build_body(ends_idle);
                send_body($urandom_range(0, 3) != 0);
                if (ends_idle && $urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                        ignored++;
                        idle_gap(pick_gap());
                    end
                end
            end
            if ((!drained && bytes_sent - start >= 300) || $urandom_range(0, 24) == 0) begin
                drained = 1'b1;
                wait_drained();
            end
        end

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d string bodies, %0d bytes decoded and %0d dropped while idle",
                 bodies, bytes_sent, ignored);
        $display("compared %0d results; status codes met (bit per code): %b",
                 checked, status_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
